// ===== rtl/lrfs_pkg.sv =====
// ---------------------------------------------------------------------------
// lrfs_pkg: shared types and constants of the rectangle fill serializer
// beat payloads, the queued command word and the display command codes
// ---------------------------------------------------------------------------
package lrfs_pkg;

   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
   localparam logic [7:0] BYTE_MSB         = 8'h80;
   localparam int         FRAME_BITS       = 9;
   localparam int         PIXEL_BITS       = 17;

   // operation codes of a request beat
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] col_start;
      logic [7:0] col_end;
      logic [7:0] page_start;
      logic [7:0] page_end;
      logic [7:0] fill_color;
   } req_type;

   typedef struct packed {
      logic bit_valid;
      logic select_active;
      logic serial_bit;
      logic frame_first;
      logic fill_last;
      logic busy_res;
      logic request_rejected;
   } rsp_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic                  is_tick;
      logic                  range_ok;
      logic [7:0]            col_start;
      logic [7:0]            col_end;
      logic [7:0]            page_start;
      logic [7:0]            page_end;
      logic [7:0]            fill_color;
      logic [PIXEL_BITS-1:0] pixel_count;
   } cmd_type;

endpackage

// ===== rtl/lcd_rect_fill_serializer.sv =====
// ---------------------------------------------------------------------------
// lcd_rect_fill_serializer: rectangle fill to 9-bit serial frames
// turns one fill request into display controller frames, one bit per tick
// ---------------------------------------------------------------------------
// usage
//   req channel: a beat with operation start latches the rectangle and color
//   (refused with request_rejected when busy or an end lies below its start);
//   a beat with operation tick asks for the next serial bit
//   rsp channel: exactly one beat per request beat, in order, carrying the
//   data line bit, chip select, frame and fill markers and the busy flag
//   frames per fill: column set, x1, x2, page set, y1, y2, memory write,
//   then the color byte once per pixel, each frame a dc bit plus 8 bits
// throughput: one beat per cycle while rsp is not stalled; the sequencer state is
//   updated once per beat, so nothing limits it below that
// order: an accepted beat is written into the queue, then popped into the
//   output register, from which the rsp side takes it
// stall: a stalled rsp holds its beat; the two-entry queue keeps taking
//   req beats until full, then req_stall rises
// reset: clears the queue, the output valid flag and the sequencer to idle
// ---------------------------------------------------------------------------
module lcd_rect_fill_serializer #(
   parameter int COORD_WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lrfs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrfs_pkg::rsp_type rsp_payload
);
   import lrfs_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_pop;
   logic    queue_push;

   // queue full is the only source of request back pressure
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   // front: mask, range check and pixel count sizing
   lrfs_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .req_payload(req_payload),
      .cmd        (front_cmd)
   );

   // short queue so each side can stall on its own
   lrfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_data(front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .not_empty(queue_not_empty),
      .pop_data (queue_cmd)
   );

   // back: frame sequencer, shift register and output beat register
   lrfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_not_empty),
      .cmd        (queue_cmd),
      .cmd_pop    (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== rtl/lrfs_front.sv =====
// ---------------------------------------------------------------------------
// lrfs_front: request classifier
// masks coordinates, checks the ranges and sizes the pixel count
// ---------------------------------------------------------------------------
module lrfs_front #(
   parameter int COORD_WIDTH = 8
) (
   input  lrfs_pkg::req_type req_payload,
   output lrfs_pkg::cmd_type cmd
);
   import lrfs_pkg::*;

   localparam int         KEEP_BITS  = (COORD_WIDTH < 8) ? COORD_WIDTH : 8;
   localparam logic [7:0] COORD_MASK = 8'((1 << KEEP_BITS) - 1);

   logic [7:0] xs, xe, ys, ye;
   logic [8:0] col_span, page_span;

   always_comb begin
      xs = req_payload.col_start  & COORD_MASK;
      xe = req_payload.col_end    & COORD_MASK;
      ys = req_payload.page_start & COORD_MASK;
      ye = req_payload.page_end   & COORD_MASK;
      col_span  = {1'b0, xe} - {1'b0, xs} + 9'd1;
      page_span = {1'b0, ye} - {1'b0, ys} + 9'd1;

      cmd.is_tick     = (req_payload.operation == OP_TICK);
      cmd.range_ok    = (xe >= xs) && (ye >= ys);
      cmd.col_start   = xs;
      cmd.col_end     = xe;
      cmd.page_start  = ys;
      cmd.page_end    = ye;
      cmd.fill_color  = req_payload.fill_color;
      // spans widened first so a full 256 by 256 product keeps its top bit
      cmd.pixel_count = PIXEL_BITS'(col_span) * PIXEL_BITS'(page_span);
   end

endmodule

// ===== rtl/lrfs_queue.sv =====
// ---------------------------------------------------------------------------
// lrfs_queue: two-entry command queue
// decouples the request side from the serializing back end
// ---------------------------------------------------------------------------
module lrfs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrfs_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lrfs_pkg::cmd_type pop_data
);
   import lrfs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// ===== rtl/lrfs_back.sv =====
// ---------------------------------------------------------------------------
// lrfs_back: frame sequencer and bit serializer
// runs the fill sequence and drives the registered result beat
// ---------------------------------------------------------------------------
module lrfs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lrfs_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrfs_pkg::rsp_type rsp_payload
);
   import lrfs_pkg::*;

   typedef enum logic [2:0] {
      PH_COL_CMD,
      PH_COL_START,
      PH_COL_END,
      PH_PAGE_CMD,
      PH_PAGE_START,
      PH_PAGE_END,
      PH_WRITE_CMD,
      PH_COLOR
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [3:0]            bit_idx_ff, bit_idx_in;
   logic [PIXEL_BITS-1:0] pixels_ff, pixels_in, pixels_dec;
   logic [8:0]            shift_ff, shift_in, cur_word, frame_word;
   logic [7:0]            xs_ff, xs_in, xe_ff, xe_in;
   logic [7:0]            ys_ff, ys_in, ye_ff, ye_in;
   logic [7:0]            color_ff, color_in;
   logic                  active_ff, active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign cmd_pop     = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // dc bit and byte of the frame for the current phase
   always_comb begin
      case (phase_ff)
         PH_COL_CMD:    frame_word = {1'b0, CMD_COLUMN_SET};
         PH_COL_START:  frame_word = {1'b1, xs_ff};
         PH_COL_END:    frame_word = {1'b1, xe_ff};
         PH_PAGE_CMD:   frame_word = {1'b0, CMD_PAGE_SET};
         PH_PAGE_START: frame_word = {1'b1, ys_ff};
         PH_PAGE_END:   frame_word = {1'b1, ye_ff};
         PH_WRITE_CMD:  frame_word = {1'b0, CMD_MEMORY_WRITE};
         PH_COLOR:      frame_word = {1'b1, color_ff};
         default:       frame_word = {1'b1, color_ff};
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      bit_idx_in = bit_idx_ff;
      pixels_in = pixels_ff;
      shift_in  = shift_ff;
      xs_in     = xs_ff;
      xe_in     = xe_ff;
      ys_in     = ys_ff;
      ye_in     = ye_ff;
      color_in  = color_ff;
      active_in = active_ff;
      rsp_in    = rsp_ff;
      cur_word  = (bit_idx_ff == 4'd0) ? frame_word : shift_ff;
      pixels_dec = (pixels_ff != '0) ? pixels_ff - PIXEL_BITS'(1) : pixels_ff;

      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (cmd_pop) begin
         rsp_in = '0;
         if (!cmd.is_tick) begin
            if (active_ff || !cmd.range_ok) begin
               rsp_in.request_rejected = 1'b1;
            end else begin
               xs_in      = cmd.col_start;
               xe_in      = cmd.col_end;
               ys_in      = cmd.page_start;
               ye_in      = cmd.page_end;
               color_in   = cmd.fill_color;
               pixels_in  = cmd.pixel_count;
               phase_in   = PH_COL_CMD;
               bit_idx_in = 4'd0;
               shift_in   = '0;
               active_in  = 1'b1;
            end
         end else if (active_ff) begin
            rsp_in.bit_valid     = 1'b1;
            rsp_in.select_active = 1'b1;
            rsp_in.frame_first   = (bit_idx_ff == 4'd0);
            rsp_in.serial_bit    = cur_word[8];
            shift_in             = {cur_word[7:0], 1'b0};
            bit_idx_in           = bit_idx_ff + 4'd1;
            if (bit_idx_ff == 4'(FRAME_BITS - 1)) begin
               bit_idx_in = 4'd0;
               if (phase_ff != PH_COLOR) begin
                  phase_in = phase_type'(phase_ff + 3'd1);
               end else begin
                  pixels_in = pixels_dec;
                  if (pixels_dec == '0) begin
                     rsp_in.fill_last = 1'b1;
                     active_in        = 1'b0;
                     phase_in         = PH_COL_CMD;
                  end
               end
            end
         end
         rsp_in.busy_res = active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COL_CMD;
         bit_idx_ff   <= 4'd0;
         pixels_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_idx_ff   <= bit_idx_in;
         pixels_ff    <= pixels_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff <= shift_in;
      xs_ff    <= xs_in;
      xe_ff    <= xe_in;
      ys_ff    <= ys_in;
      ye_ff    <= ye_in;
      color_ff <= color_in;
      rsp_ff   <= rsp_in;
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> bit_idx_ff == 4'd0 && phase_ff == PH_COL_CMD)
      else $error("idle with frame in progress");

   a_bit_idx_range: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff < 4'(FRAME_BITS))
      else $error("bit index past frame end");

   a_last_ends_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fill_last |-> rsp_ff.bit_valid && !rsp_ff.busy_res)
      else $error("fill_last without ending the fill");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && !cmd.is_tick && !active_ff && cmd.range_ok |=> active_ff)
      else $error("good start did not begin a fill");

endmodule
